// ===== rtl/core/u2a_pkg.sv =====
// package: widths, reset map, lead and entry length helpers, result types
`timescale 1ns / 1ps
`default_nettype none

package u2a_pkg;

    localparam int BYTE_W              = 8;
    localparam int SEQ_W               = 32;
    localparam int SEQ_BYTES           = SEQ_W / BYTE_W;
    localparam int ENTRY_W             = 40;
    localparam int LEN_W               = 3;
    localparam int NUM_REGS            = 4;
    localparam int MAP_ENTRIES_DEFAULT = 4;
    localparam int CFG_INDEX_W         = 8;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [BYTE_W-1:0] UNKNOWN_CHAR = 8'h3F;
    localparam logic [BYTE_W-1:0] TERM_CHAR    = 8'h00;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // CE A1 -> a, CE A9 -> e, CE B3 -> u, E2 80 99 -> apostrophe
    localparam logic [ENTRY_W-1:0] MAP_RESET [NUM_REGS] = '{
        40'h61_0000_A1CE,
        40'h65_0000_A9CE,
        40'h75_0000_B3CE,
        40'h27_0099_80E2
    };

    typedef struct packed {
        logic [BYTE_W-1:0] out_char;
        logic              end_of_text;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            len = LEN_W'(2);
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            len = LEN_W'(3);
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            len = LEN_W'(4);
        end
        else
        begin
            len = LEN_W'(1);
        end
        return len;
    endfunction

    // count of bytes before the first zero byte
    function automatic logic [LEN_W-1:0] entry_length(input logic [SEQ_W-1:0] e);
        logic [LEN_W-1:0] len;
        if (e[7:0] == 8'h00)
        begin
            len = LEN_W'(0);
        end
        else if (e[15:8] == 8'h00)
        begin
            len = LEN_W'(1);
        end
        else if (e[23:16] == 8'h00)
        begin
            len = LEN_W'(2);
        end
        else if (e[31:24] == 8'h00)
        begin
            len = LEN_W'(3);
        end
        else
        begin
            len = LEN_W'(4);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u2a_text_if.sv =====
// interface: incoming utf-8 text byte channel
`timescale 1ns / 1ps
`default_nettype none

interface u2a_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u2a_char_if.sv =====
// interface: outgoing ascii character channel
`timescale 1ns / 1ps
`default_nettype none

interface u2a_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_text;

    modport source (output valid, output out_char, output end_of_text, input ready);
    modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u2a_cfg_if.sv =====
// interface: map entry register write channel
`timescale 1ns / 1ps
`default_nettype none

interface u2a_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [39:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u2a_match.sv =====
// map lookup: parallel compare of a collected sequence against all entries
`timescale 1ns / 1ps
`default_nettype none

module u2a_match #(
    parameter int N_ENTRIES = u2a_pkg::NUM_REGS
) (
    input  wire logic [u2a_pkg::SEQ_W-1:0]  entry_bytes [N_ENTRIES],
    input  wire logic [u2a_pkg::BYTE_W-1:0] entry_chars [N_ENTRIES],
    input  wire logic [u2a_pkg::LEN_W-1:0]  entry_lens  [N_ENTRIES],
    input  wire logic [u2a_pkg::SEQ_W-1:0]  seq_bytes,
    input  wire logic [u2a_pkg::LEN_W-1:0]  seq_len,
    output logic      [u2a_pkg::BYTE_W-1:0] match_char
);
    import u2a_pkg::*;

    logic [N_ENTRIES-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < N_ENTRIES; k++)
        begin
            hit[k] = (entry_lens[k] == seq_len);
            for (int i = 0; i < SEQ_BYTES; i++)
            begin
                // bytes past the sequence length are don't care
                if ((entry_bytes[k][i*BYTE_W +: BYTE_W] != seq_bytes[i*BYTE_W +: BYTE_W])
                    && (LEN_W'(i) < seq_len))
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    // first matching entry wins
    always_comb
    begin
        match_char = UNKNOWN_CHAR;
        for (int k = N_ENTRIES - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                match_char = entry_chars[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u2a_result_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none

module u2a_result_fifo #(
    parameter int DEPTH = u2a_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire u2a_pkg::push_t   push,
    input  wire logic             pop,
    output logic                  out_valid,
    output u2a_pkg::result_t      head,
    output logic                  room
);
    import u2a_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign out_valid    = (count_reg != CNT_W'(0));
    assign head         = mem[rd_ptr_reg];
    // an item may bring two results
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_ascii_transliterator_unit.sv =====
// top level: utf-8 to ascii transliterator with configurable map entries
//
//  channel | role    | payload                    | transaction
//  --------+---------+----------------------------+----------------------------
//  text    | sink    | text_byte                  | valid && ready
//  chars   | source  | out_char, end_of_text      | valid && ready
//  cfg     | sink    | index, data                | valid && ready (always ready)
//
// one text byte is taken per cycle while text ready is high; its results are
// registered in a four entry queue and leave on chars in order
// the map compare is combinational from the sequence registers and the byte
// a zero inside a sequence gives two results; text ready drops while the
// queue has fewer than two free slots
// reset closes any open sequence, empties the queue and reloads the default map
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ascii_transliterator_unit #(
    parameter int MAP_ENTRIES = u2a_pkg::MAP_ENTRIES_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    u2a_cfg_if.sink    cfg,
    u2a_text_if.sink   text,
    u2a_char_if.source chars
);
    import u2a_pkg::*;

    // entries above the register count are not stored and never match
    localparam int STORED = (MAP_ENTRIES < NUM_REGS) ? MAP_ENTRIES : NUM_REGS;

    logic [ENTRY_W-1:0] map_reg     [STORED];
    logic [LEN_W-1:0]   entry_lens  [STORED];
    logic [SEQ_W-1:0]   entry_bytes [STORED];
    logic [BYTE_W-1:0]  entry_chars [STORED];

    logic [SEQ_W-1:0]   seq_reg;
    logic [SEQ_W-1:0]   seq_next;
    logic [LEN_W-1:0]   exp_len_reg;
    logic [LEN_W-1:0]   exp_len_next;
    logic [LEN_W-1:0]   collected_reg;
    logic [LEN_W-1:0]   collected_next;

    logic               cfg_write;
    logic               text_accept;
    logic               fifo_room;
    logic               fifo_valid;
    result_t            fifo_head;
    push_t              push;

    logic [BYTE_W-1:0]  b;
    logic [LEN_W-1:0]   lead_len;
    logic [SEQ_W-1:0]   seq_cat;
    logic [LEN_W-1:0]   collected_inc;
    logic [SEQ_W-1:0]   lookup_bytes;
    logic [LEN_W-1:0]   lookup_len;
    logic [BYTE_W-1:0]  match_char;

    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && cfg.ready;
    assign text.ready  = fifo_room;
    assign text_accept = text.valid && text.ready;

    for (genvar k = 0; k < STORED; k++)
    begin : g_map
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                map_reg[k]    <= MAP_RESET[k];
                entry_lens[k] <= entry_length(MAP_RESET[k][SEQ_W-1:0]);
            end
            else if (cfg_write && (cfg.index == CFG_INDEX_W'(k)))
            begin
                map_reg[k]    <= cfg.data;
                entry_lens[k] <= entry_length(cfg.data[SEQ_W-1:0]);
            end
        end
        assign entry_bytes[k] = map_reg[k][SEQ_W-1:0];
        assign entry_chars[k] = map_reg[k][ENTRY_W-1:SEQ_W];
    end

    assign b             = text.text_byte;
    assign lead_len      = lead_length(b);
    assign collected_inc = collected_reg + LEN_W'(1);
    // new byte lands after the bytes already collected
    assign seq_cat       = seq_reg | (SEQ_W'(b) << {collected_reg[1:0], 3'b000});

    always_comb
    begin
        if (exp_len_reg == LEN_W'(0))
        begin
            lookup_bytes = SEQ_W'(b);
            lookup_len   = lead_len;
        end
        else
        begin
            lookup_bytes = seq_cat;
            lookup_len   = exp_len_reg;
        end
    end

    u2a_match #(
        .N_ENTRIES (STORED)
    ) u_match (
        .entry_bytes (entry_bytes),
        .entry_chars (entry_chars),
        .entry_lens  (entry_lens),
        .seq_bytes   (lookup_bytes),
        .seq_len     (lookup_len),
        .match_char  (match_char)
    );

    always_comb
    begin
        seq_next       = seq_reg;
        exp_len_next   = exp_len_reg;
        collected_next = collected_reg;
        push.count     = 2'd0;
        push.first     = '{out_char: match_char, end_of_text: 1'b0};
        push.second    = '{out_char: TERM_CHAR, end_of_text: 1'b1};
        if (text_accept)
        begin
            if (exp_len_reg == LEN_W'(0))
            begin
                if (b == 8'h00)
                begin
                    push.count = 2'd1;
                    push.first = '{out_char: TERM_CHAR, end_of_text: 1'b1};
                end
                else if (!b[BYTE_W-1])
                begin
                    push.count = 2'd1;
                    push.first = '{out_char: b, end_of_text: 1'b0};
                end
                else if (lead_len == LEN_W'(1))
                begin
                    // invalid lead is a one byte sequence, looked up at once
                    push.count = 2'd1;
                end
                else
                begin
                    seq_next       = SEQ_W'(b);
                    exp_len_next   = lead_len;
                    collected_next = LEN_W'(1);
                end
            end
            else if (b == 8'h00)
            begin
                // zero cuts the sequence short: unknown mark, then terminator
                push.count     = 2'd2;
                push.first     = '{out_char: UNKNOWN_CHAR, end_of_text: 1'b0};
                seq_next       = '0;
                exp_len_next   = '0;
                collected_next = '0;
            end
            else if (collected_inc >= exp_len_reg)
            begin
                push.count     = 2'd1;
                seq_next       = '0;
                exp_len_next   = '0;
                collected_next = '0;
            end
            else
            begin
                seq_next       = seq_cat;
                collected_next = collected_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            exp_len_reg   <= '0;
            collected_reg <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            exp_len_reg   <= exp_len_next;
            collected_reg <= collected_next;
        end
    end

    u2a_result_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (chars.valid && chars.ready),
        .out_valid (fifo_valid),
        .head      (fifo_head),
        .room      (fifo_room)
    );

    assign chars.valid       = fifo_valid;
    assign chars.out_char    = fifo_head.out_char;
    assign chars.end_of_text = fifo_head.end_of_text;

    a_closed_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg == LEN_W'(0)) |-> (collected_reg == LEN_W'(0)))
        else $error("bytes counted with no sequence open");

    a_open_is_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg != LEN_W'(0)) |->
        ((collected_reg < exp_len_reg) && (exp_len_reg != LEN_W'(1))))
        else $error("open sequence already complete");

    a_zero_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (text_accept && (b == 8'h00)) |=> chars.valid)
        else $error("zero byte left no result");

    a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> chars.valid)
        else $error("input stalled with an empty result queue");

endmodule

`default_nettype wire
